// ===== rtl/lru_key_value_cache_unit_macros.svh =====
// assertion macros shared by the checker of the lru key/value cache unit
// depends on: nothing; the including module must have clock and reset
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
// shared types and constants of the lru key/value cache unit
// depends on: nothing
`default_nettype none

package lkvc_pkg;

   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   // operation codes carried in tuser of the request
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // reset value of the capacity register
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // read value returned by a get that misses
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch request and lookup results
      logic commit;    // update entries and load the response beat
   } ctl_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/lru_key_value_cache_unit.sv =====
// top level of the lru key/value cache unit: controller plus datapath
// depends on: lkvc_pkg, lkvc_ctrl, lkvc_datapath
//
// channel  | dir | handshake             | payload
// req      | in  | req_tvalid/req_tready | tdata: key, value; tuser: opcode
// rsp      | out | rsp_tvalid/rsp_tready | tdata: read_value, evicted_key;
//          |     |                       | tuser: found, evicted
// csr      | in  | csr_wr_en             | csr_wr_data: capacity
//
// each beat has a lookup, the key compare against all entries on the accept edge,
// then the recency update and entry write in the update state.
// a finished response waits in an output register; a new beat is accepted
// meanwhile, and the update cycle stalls only while that register is still full.
// reset clears all entries at once and sets capacity to 16.
`default_nettype none

module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [63:0]        req_tdata,   // [31:0] key, [63:32] value
   input  wire logic               req_tuser,   // [0] opcode
   // response channel
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [63:0]             rsp_tdata,   // [31:0] read_value, [63:32] evicted_key
   output logic [1:0]              rsp_tuser,   // [0] found, [1] evicted
   // capacity register
   input  wire logic               csr_wr_en,
   input  wire logic [CAP_W-1:0]   csr_wr_data
);

   ctl_cmd_type       cmd;
   logic              found;
   logic              evicted;
   logic [DATA_W-1:0] read_value;
   logic [KEY_W-1:0]  evicted_key;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_opcode      (req_tuser),
      .req_key         (req_tdata[31:0]),
      .req_value       (req_tdata[63:32]),
      .rsp_found       (found),
      .rsp_read_value  (read_value),
      .rsp_evicted     (evicted),
      .rsp_evicted_key (evicted_key)
   );

   // response packing
   assign rsp_tdata = {evicted_key, read_value};
   assign rsp_tuser = {evicted, found};

endmodule

`default_nettype wire

// ===== rtl/lkvc_ctrl.sv =====
// controller of the lru key/value cache unit: handshakes and sequencing
// depends on: lkvc_pkg
`default_nettype none

module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output ctl_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // commit once the response register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response beat valid
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lkvc_datapath.sv =====
// datapath of the lru key/value cache unit: entry registers, key compare,
// recency ranks, capacity register and response register
// depends on: lkvc_pkg
`default_nettype none

module lkvc_datapath
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_cmd_type        cmd,
   input  wire logic               csr_wr_en,
   input  wire logic [CAP_W-1:0]   csr_wr_data,
   input  wire logic               req_opcode,
   input  wire logic [KEY_W-1:0]   req_key,
   input  wire logic [DATA_W-1:0]  req_value,
   output logic                    rsp_found,
   output logic [DATA_W-1:0]       rsp_read_value,
   output logic                    rsp_evicted,
   output logic [KEY_W-1:0]        rsp_evicted_key
);

   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // entry registers
   logic [KEY_W-1:0]  entry_key_ff   [ENTRIES];
   logic [KEY_W-1:0]  entry_key_in   [ENTRIES];
   logic [DATA_W-1:0] entry_value_ff [ENTRIES];
   logic [DATA_W-1:0] entry_value_in [ENTRIES];
   logic [AGE_W-1:0]  entry_age_ff   [ENTRIES];
   logic [AGE_W-1:0]  entry_age_in   [ENTRIES];
   logic [ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [CNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;

   // captured request and lookup vectors
   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [ENTRIES-1:0] hit_ff, hit_in;
   logic [ENTRIES-1:0] oldest_ff, oldest_in;
   logic [ENTRIES-1:0] free_ff, free_in;

   // response register
   logic               found_ff, found_in;
   logic [DATA_W-1:0]  read_value_ff, read_value_in;
   logic               evicted_ff, evicted_in;
   logic [KEY_W-1:0]   evicted_key_ff, evicted_key_in;

   // update stage signals
   logic               hit_any;
   logic [DATA_W-1:0]  hit_value;
   logic [AGE_W-1:0]   hit_age;
   logic [KEY_W-1:0]   oldest_key;
   logic [CMP_W-1:0]   eff_cap;
   logic [CMP_W-1:0]   count_ext;
   logic               do_insert;
   logic               do_evict;
   logic [ENTRIES-1:0] dst_vec;
   logic [AGE_W-1:0]   lru_age;
   logic [ENTRIES-1:0] invalid_vec;

   // capacity register
   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   // lookup on the incoming beat: key compare, oldest entry, first free slot
   assign lru_age     = AGE_W'(entry_count_ff - CNT_W'(1));
   assign invalid_vec = ~entry_valid_ff;
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_in[i]    = entry_valid_ff[i] && (entry_key_ff[i] == req_key);
         oldest_in[i] = entry_valid_ff[i] && (entry_age_ff[i] == lru_age);
      end
      free_in = invalid_vec & (~invalid_vec + ENTRIES'(1));
   end

   assign op_in    = cmd.capture ? req_opcode : op_ff;
   assign key_in   = cmd.capture ? req_key    : key_ff;
   assign value_in = cmd.capture ? req_value  : value_ff;

   // selection of the hit and oldest entries
   always_comb begin
      hit_value  = '0;
      hit_age    = '0;
      oldest_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value  = hit_value  | (entry_value_ff[i] & {DATA_W{hit_ff[i]}});
         hit_age    = hit_age    | (entry_age_ff[i]   & {AGE_W{hit_ff[i]}});
         oldest_key = oldest_key | (entry_key_ff[i]   & {KEY_W{oldest_ff[i]}});
      end
   end

   // capacity clamped to one up to the entry count
   always_comb begin
      eff_cap = CMP_W'(capacity_ff);
      if (eff_cap == '0) begin
         eff_cap = CMP_W'(1);
      end else if (eff_cap > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end
   end

   assign count_ext = CMP_W'(entry_count_ff);
   assign hit_any   = |hit_ff;
   assign do_insert = (op_ff == OP_PUT) && !hit_any;
   assign do_evict  = do_insert && (count_ext >= eff_cap);
   assign dst_vec   = do_evict ? oldest_ff : free_ff;

   // entry update on commit
   always_comb begin
      entry_valid_in = entry_valid_ff;
      entry_count_in = entry_count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         entry_key_in[i]   = entry_key_ff[i];
         entry_value_in[i] = entry_value_ff[i];
         entry_age_in[i]   = entry_age_ff[i];
         if (cmd.commit) begin
            if (hit_any) begin
               // move the hit entry to the front, younger ones age by one
               if (hit_ff[i]) begin
                  entry_age_in[i] = '0;
                  if (op_ff == OP_PUT) begin
                     entry_value_in[i] = value_ff;
                  end
               end else if (entry_valid_ff[i] && (entry_age_ff[i] < hit_age)) begin
                  entry_age_in[i] = entry_age_ff[i] + AGE_W'(1);
               end
            end else if (do_insert) begin
               // new key takes the free or evicted slot, all others age
               if (dst_vec[i]) begin
                  entry_valid_in[i] = 1'b1;
                  entry_key_in[i]   = key_ff;
                  entry_value_in[i] = value_ff;
                  entry_age_in[i]   = '0;
               end else if (entry_valid_ff[i]) begin
                  entry_age_in[i] = entry_age_ff[i] + AGE_W'(1);
               end
            end
         end
      end
      if (cmd.commit && do_insert && !do_evict) begin
         entry_count_in = entry_count_ff + CNT_W'(1);
      end
   end

   // response beat
   always_comb begin
      found_in       = found_ff;
      read_value_in  = read_value_ff;
      evicted_in     = evicted_ff;
      evicted_key_in = evicted_key_ff;
      if (cmd.commit) begin
         found_in       = hit_any;
         evicted_in     = do_evict;
         evicted_key_in = do_evict ? oldest_key : '0;
         if (op_ff == OP_GET) begin
            read_value_in = hit_any ? hit_value : MISS_VALUE;
         end else begin
            read_value_in = '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         entry_count_ff <= '0;
         capacity_ff    <= CAP_RESET;
      end else begin
         entry_valid_ff <= entry_valid_in;
         entry_count_ff <= entry_count_in;
         capacity_ff    <= capacity_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         entry_key_ff[i]   <= entry_key_in[i];
         entry_value_ff[i] <= entry_value_in[i];
         entry_age_ff[i]   <= entry_age_in[i];
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      if (cmd.capture) begin
         hit_ff    <= hit_in;
         oldest_ff <= oldest_in;
         free_ff   <= free_in;
      end
      found_ff       <= found_in;
      read_value_ff  <= read_value_in;
      evicted_ff     <= evicted_in;
      evicted_key_ff <= evicted_key_in;
   end

   assign rsp_found       = found_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

endmodule

`default_nettype wire

// ===== rtl/lkvc_checker.sv =====
// port-level checks of the lru key/value cache unit, bound to the top level
// depends on: lru_key_value_cache_unit_macros.svh, lru_key_value_cache_unit
`default_nettype none

`include "lru_key_value_cache_unit_macros.svh"

module lkvc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled response beat holds its data
   `LKVC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response beat changed while stalled")

   // one beat at a time: no accept right after an accept
   `LKVC_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "request accepted during update cycle")

   // an eviction only comes from a put of a new key
   `LKVC_ASSERT_SAME(a_evict_is_put_miss, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0] && (rsp_tdata[31:0] == 32'h0), "eviction on a hit or with nonzero read value")

   // no eviction means no evicted key
   `LKVC_ASSERT_SAME(a_no_evict_zero_key, rsp_tvalid && !rsp_tuser[1], rsp_tdata[63:32] == 32'h0, "evicted key set without eviction")

endmodule

bind lru_key_value_cache_unit lkvc_checker u_checker (.*);

`default_nettype wire
